FILE: sv/assert_macros.svh
// Assertion helpers shared by the RTL of the quaternion unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while the block is out of reset.
`define RMQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define RMQ_ASSERT_NORST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Widths, payload structs and branch codes used across the pipeline.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int DATA_WIDTH = 24;
  localparam int FRAC_BITS  = 22;

  localparam int SUM_W  = DATA_WIDTH + 2;
  localparam int RAD_W  = DATA_WIDTH + 1;
  localparam int ROOT_W = (RAD_W + FRAC_BITS + 1) / 2;
  localparam int DEN_W  = ROOT_W + 1;
  localparam int DIF_W  = DATA_WIDTH + 1;
  localparam int MAG_W  = DATA_WIDTH + 1;
  localparam int QB     = DATA_WIDTH + 1;
  localparam int PRE_SH = QB - FRAC_BITS;
  localparam int NLANE  = 3;

  localparam logic [1:0] BR_TRACE = 2'd0;
  localparam logic [1:0] BR_X     = 2'd1;
  localparam logic [1:0] BR_Y     = 2'd2;
  localparam logic [1:0] BR_Z     = 2'd3;

  typedef logic signed [DATA_WIDTH-1:0] elem_t;
  typedef logic signed [DIF_W-1:0] dif_t;

  typedef struct packed {
    elem_t m00;
    elem_t m01;
    elem_t m02;
    elem_t m10;
    elem_t m11;
    elem_t m12;
    elem_t m20;
    elem_t m21;
    elem_t m22;
  } rmq_in_t;

  typedef struct packed {
    elem_t      qw;
    elem_t      qx;
    elem_t      qy;
    elem_t      qz;
    logic [1:0] branch_taken;
    logic       bad_input;
  } rmq_out_t;

  typedef struct packed {
    dif_t [NLANE-1:0] d;
    logic [1:0]       br;
    logic             bad;
  } rmq_side_t;

  typedef struct packed {
    logic [RAD_W-1:0] r;
    rmq_side_t        side;
  } rmq_front_t;

  typedef struct packed {
    logic [ROOT_W-2:0] half;
    logic [1:0]        br;
    logic              bad;
  } rmq_dside_t;

endpackage

FILE: sv/rmq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front stage
// Forms the trace, picks the branch, and registers radicand and pair terms.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               v_i,
  input  rmq_pkg::rmq_in_t   m_i,
  output logic               v_o,
  output rmq_pkg::rmq_front_t f_o
);
  import rmq_pkg::*;

  logic        v_r;
  rmq_front_t  f_r, f_nxt;

  always_comb begin
    logic signed [SUM_W-1:0] e00, e11, e22, one, trace, rad;
    e00   = SUM_W'(m_i.m00);
    e11   = SUM_W'(m_i.m11);
    e22   = SUM_W'(m_i.m22);
    one   = SUM_W'(1) << FRAC_BITS;
    trace = e00 + e11 + e22;
    f_nxt = '0;
    if (trace > 0) begin
      f_nxt.side.br   = BR_TRACE;
      rad             = one + trace;
      f_nxt.side.d[0] = DIF_W'(m_i.m21) - DIF_W'(m_i.m12);
      f_nxt.side.d[1] = DIF_W'(m_i.m02) - DIF_W'(m_i.m20);
      f_nxt.side.d[2] = DIF_W'(m_i.m10) - DIF_W'(m_i.m01);
    end else if (m_i.m00 > m_i.m11 && m_i.m00 > m_i.m22) begin
      f_nxt.side.br   = BR_X;
      rad             = one + e00 - e11 - e22;
      f_nxt.side.d[0] = DIF_W'(m_i.m21) - DIF_W'(m_i.m12);
      f_nxt.side.d[1] = DIF_W'(m_i.m10) + DIF_W'(m_i.m01);
      f_nxt.side.d[2] = DIF_W'(m_i.m02) + DIF_W'(m_i.m20);
    end else if (m_i.m11 > m_i.m22) begin
      f_nxt.side.br   = BR_Y;
      rad             = one + e11 - e00 - e22;
      f_nxt.side.d[0] = DIF_W'(m_i.m02) - DIF_W'(m_i.m20);
      f_nxt.side.d[1] = DIF_W'(m_i.m10) + DIF_W'(m_i.m01);
      f_nxt.side.d[2] = DIF_W'(m_i.m21) + DIF_W'(m_i.m12);
    end else begin
      f_nxt.side.br   = BR_Z;
      rad             = one + e22 - e00 - e11;
      f_nxt.side.d[0] = DIF_W'(m_i.m10) - DIF_W'(m_i.m01);
      f_nxt.side.d[1] = DIF_W'(m_i.m02) + DIF_W'(m_i.m20);
      f_nxt.side.d[2] = DIF_W'(m_i.m21) + DIF_W'(m_i.m12);
    end
    f_nxt.side.bad = (rad <= 0);
    f_nxt.r        = rad[RAD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_r <= f_nxt;
    end
  end

  assign v_o = v_r;
  assign f_o = f_r;

endmodule

FILE: sv/rmq_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Square root pipeline
// Restoring integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
module rmq_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        v_i,
  input  rmq_pkg::rmq_front_t         f_i,
  output logic                        v_o,
  output logic [rmq_pkg::ROOT_W-1:0]  root_o,
  output rmq_pkg::rmq_side_t          side_o
);
  import rmq_pkg::*;

  localparam int NP = ROOT_W;

  logic              v_r    [NP];
  logic [ROOT_W:0]   rem_r  [NP];
  logic [ROOT_W:0]   rem_nxt[NP];
  logic [ROOT_W-1:0] root_r [NP];
  logic [ROOT_W-1:0] root_nxt[NP];
  logic [RAD_W-1:0]  rad_r  [NP];
  rmq_side_t         side_r [NP];

  function automatic logic rad_bit(input logic [RAD_W-1:0] r, input int b);
    if (b >= FRAC_BITS && b < FRAC_BITS + RAD_W) begin
      return r[b-FRAC_BITS];
    end
    return 1'b0;
  endfunction

  always_comb begin
    logic [ROOT_W:0]   rem_p;
    logic [ROOT_W-1:0] root_p;
    logic [RAD_W-1:0]  rad_p;
    logic [ROOT_W+2:0] cur, trial, diff;
    for (int j = 0; j < NP; j++) begin
      if (j == 0) begin
        rem_p  = '0;
        root_p = '0;
        rad_p  = f_i.r;
      end else begin
        rem_p  = rem_r[j-1];
        root_p = root_r[j-1];
        rad_p  = rad_r[j-1];
      end
      cur   = {rem_p, rad_bit(rad_p, 2 * (NP - 1 - j) + 1), rad_bit(rad_p, 2 * (NP - 1 - j))};
      trial = {1'b0, root_p, 2'b01};
      diff  = cur - trial;
      if (cur >= trial) begin
        rem_nxt[j]  = diff[ROOT_W:0];
        root_nxt[j] = {root_p[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt[j]  = cur[ROOT_W:0];
        root_nxt[j] = {root_p[ROOT_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NP; j++) begin
        v_r[j] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= v_i;
      for (int j = 1; j < NP; j++) begin
        v_r[j] <= v_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= f_i.r;
      side_r[0] <= f_i.side;
      for (int j = 1; j < NP; j++) begin
        rad_r[j]  <= rad_r[j-1];
        side_r[j] <= side_r[j-1];
      end
      for (int j = 0; j < NP; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
      end
    end
  end

  assign v_o    = v_r[NP-1];
  assign root_o = root_r[NP-1];
  assign side_o = side_r[NP-1];

endmodule

FILE: sv/rmq_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Divider pipeline
// Three restoring divider lanes, one quotient bit per register stage,
// dividing each pair term by twice the root.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rmq_div (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       en,
  input  logic                                       v_i,
  input  logic [rmq_pkg::ROOT_W-1:0]                 root_i,
  input  rmq_pkg::rmq_side_t                         side_i,
  output logic                                       v_o,
  output logic [rmq_pkg::NLANE-1:0][rmq_pkg::QB-1:0] q_o,
  output logic [rmq_pkg::NLANE-1:0]                  ovf_o,
  output logic [rmq_pkg::NLANE-1:0]                  neg_o,
  output rmq_pkg::rmq_dside_t                        ds_o
);
  import rmq_pkg::*;

  localparam int NS    = QB + 1;
  localparam int CMP_W = (MAG_W > DEN_W) ? MAG_W : DEN_W;

  logic                          v_r   [NS];
  logic [DEN_W-1:0]              den_r [NS];
  logic [NLANE-1:0][DEN_W-1:0]   rem_r [NS];
  logic [NLANE-1:0][DEN_W-1:0]   rem_nxt[NS];
  logic [NLANE-1:0][QB-1:0]      q_r   [NS];
  logic [NLANE-1:0][QB-1:0]      q_nxt [NS];
  logic [NLANE-1:0][MAG_W-1:0]   a_r   [NS];
  logic [NLANE-1:0][MAG_W-1:0]   a_nxt0;
  logic [NLANE-1:0]              neg_r [NS];
  logic [NLANE-1:0]              neg_nxt0;
  logic [NLANE-1:0]              ovf_r [NS];
  logic [NLANE-1:0]              ovf_nxt0;
  rmq_dside_t                    ds_r  [NS];
  logic [DEN_W-1:0]              den_in;

  assign den_in = {root_i, 1'b0};

  always_comb begin
    logic [MAG_W-1:0] pre;
    logic [DEN_W:0]   cur, diff;
    logic             bit_in;
    for (int l = 0; l < NLANE; l++) begin
      neg_nxt0[l]   = side_i.d[l][DIF_W-1];
      a_nxt0[l]     = neg_nxt0[l] ? MAG_W'(-side_i.d[l]) : MAG_W'(side_i.d[l]);
      pre           = a_nxt0[l] >> PRE_SH;
      ovf_nxt0[l]   = CMP_W'(pre) >= CMP_W'(den_in);
      rem_nxt[0][l] = ovf_nxt0[l] ? '0 : DEN_W'(pre);
      q_nxt[0][l]   = '0;
    end
    for (int s = 1; s < NS; s++) begin
      for (int l = 0; l < NLANE; l++) begin
        if (QB - s >= FRAC_BITS && QB - s - FRAC_BITS < MAG_W) begin
          bit_in = a_r[s-1][l][QB-s-FRAC_BITS];
        end else begin
          bit_in = 1'b0;
        end
        cur  = {rem_r[s-1][l], bit_in};
        diff = cur - {1'b0, den_r[s-1]};
        if (cur >= {1'b0, den_r[s-1]}) begin
          rem_nxt[s][l] = diff[DEN_W-1:0];
          q_nxt[s][l]   = {q_r[s-1][l][QB-2:0], 1'b1};
        end else begin
          rem_nxt[s][l] = cur[DEN_W-1:0];
          q_nxt[s][l]   = {q_r[s-1][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NS; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (en) begin
      v_r[0] <= v_i;
      for (int s = 1; s < NS; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]   <= den_in;
      a_r[0]     <= a_nxt0;
      neg_r[0]   <= neg_nxt0;
      ovf_r[0]   <= ovf_nxt0;
      ds_r[0]    <= '{half: root_i[ROOT_W-1:1], br: side_i.br, bad: side_i.bad};
      for (int s = 1; s < NS; s++) begin
        den_r[s] <= den_r[s-1];
        a_r[s]   <= a_r[s-1];
        neg_r[s] <= neg_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
        ds_r[s]  <= ds_r[s-1];
      end
      for (int s = 0; s < NS; s++) begin
        rem_r[s] <= rem_nxt[s];
        q_r[s]   <= q_nxt[s];
      end
    end
  end

  assign v_o   = v_r[NS-1];
  assign q_o   = q_r[NS-1];
  assign ovf_o = ovf_r[NS-1];
  assign neg_o = neg_r[NS-1];
  assign ds_o  = ds_r[NS-1];

  `RMQ_ASSERT(div_rem_below_den, v_r[NS-1] && !ds_r[NS-1].bad |-> rem_r[NS-1][0] < den_r[NS-1], "divider remainder not below divisor")

endmodule

FILE: sv/rotation_matrix_to_quaternion_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion unit
// Trace-based conversion of a fixed-point 3x3 rotation matrix to (w,x,y,z).
// ----------------------------------------------------------------------------
// Channel   Ports                          Carries
// input     in_valid, in_ready, in_data    nine matrix elements, Q2.22
// result    out_valid, out_ready, out_data quaternion, branch and bad flag
//
// One request is taken per cycle unless stalled; a result passes through one
// front stage, one stage per root bit of the square root, one set-up stage
// plus one stage per quotient bit in the divider lanes, and the output register.
// The whole pipeline advances only when the output register is empty or taken.
// Reset clears only the valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rotation_matrix_to_quaternion_unit (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rmq_pkg::rmq_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output rmq_pkg::rmq_out_t out_data
);
  import rmq_pkg::*;

  logic                     en;
  logic                     fr_v, sq_v, dv_v;
  rmq_front_t               fr_f;
  logic [ROOT_W-1:0]        sq_root;
  rmq_side_t                sq_side;
  logic [NLANE-1:0][QB-1:0] dv_q;
  logic [NLANE-1:0]         dv_ovf, dv_neg;
  rmq_dside_t               dv_ds;
  logic                     out_valid_r;
  rmq_out_t                 out_data_r, out_nxt;

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  rmq_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .v_i   (in_valid),
    .m_i   (in_data),
    .v_o   (fr_v),
    .f_o   (fr_f)
  );

  rmq_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (fr_v),
    .f_i    (fr_f),
    .v_o    (sq_v),
    .root_o (sq_root),
    .side_o (sq_side)
  );

  rmq_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .v_i    (sq_v),
    .root_i (sq_root),
    .side_i (sq_side),
    .v_o    (dv_v),
    .q_o    (dv_q),
    .ovf_o  (dv_ovf),
    .neg_o  (dv_neg),
    .ds_o   (dv_ds)
  );

  function automatic elem_t sat_q(input logic [QB-1:0] q, input logic ovf, input logic neg);
    logic [QB-1:0] lim;
    lim = QB'(1) << (DATA_WIDTH - 1);
    if (!neg) begin
      if (ovf || q >= lim) begin
        return {1'b0, {(DATA_WIDTH-1){1'b1}}};
      end
      return q[DATA_WIDTH-1:0];
    end
    if (ovf || q > lim) begin
      return {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end
    return -q[DATA_WIDTH-1:0];
  endfunction

  always_comb begin
    elem_t h, l0, l1, l2;
    h  = sat_q(QB'(dv_ds.half), 1'b0, 1'b0);
    l0 = sat_q(dv_q[0], dv_ovf[0], dv_neg[0]);
    l1 = sat_q(dv_q[1], dv_ovf[1], dv_neg[1]);
    l2 = sat_q(dv_q[2], dv_ovf[2], dv_neg[2]);
    out_nxt              = '0;
    out_nxt.branch_taken = dv_ds.br;
    out_nxt.bad_input    = dv_ds.bad;
    case (dv_ds.br)
      BR_TRACE: begin
        out_nxt.qw = h;  out_nxt.qx = l0; out_nxt.qy = l1; out_nxt.qz = l2;
      end
      BR_X: begin
        out_nxt.qw = l0; out_nxt.qx = h;  out_nxt.qy = l1; out_nxt.qz = l2;
      end
      BR_Y: begin
        out_nxt.qw = l0; out_nxt.qx = l1; out_nxt.qy = h;  out_nxt.qz = l2;
      end
      BR_Z: begin
        out_nxt.qw = l0; out_nxt.qx = l1; out_nxt.qy = l2; out_nxt.qz = h;
      end
      default: begin
        out_nxt.qw = '0;
      end
    endcase
    if (dv_ds.bad) begin
      out_nxt.qw = '0;
      out_nxt.qx = '0;
      out_nxt.qy = '0;
      out_nxt.qz = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RMQ_ASSERT(bad_gives_zero, out_valid && out_data.bad_input |-> out_data.qw == 0 && out_data.qx == 0 && out_data.qy == 0 && out_data.qz == 0, "bad input result not zero")
  `RMQ_ASSERT(trace_w_nonneg, out_valid && !out_data.bad_input && out_data.branch_taken == BR_TRACE |-> !out_data.qw[DATA_WIDTH-1], "scalar part negative on trace branch")
  `RMQ_ASSERT_NORST(reset_clears_out, !rst_n |=> !out_valid, "result valid after reset")

endmodule

FILE: verif/tb_rotation_matrix_to_quaternion_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the rotation matrix to quaternion unit
// Sends directed corner matrices, proper rotations built from random
// quaternions and raw random matrices, under varying backpressure. Each
// result is checked field by field against a behavioral quaternion predictor.
// ----------------------------------------------------------------------------
module tb_rotation_matrix_to_quaternion_unit;
  import rmq_pkg::*;

  localparam longint ONE_FX = 64'sd1 << FRAC_BITS;
  localparam longint OUT_HI = (64'sd1 <<< (DATA_WIDTH - 1)) - 1;
  localparam longint OUT_LO = -(64'sd1 <<< (DATA_WIDTH - 1));
  localparam longint E_MAX  = OUT_HI;
  localparam longint E_MIN  = OUT_LO;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  rmq_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rmq_out_t out_data;

  rmq_out_t quat_expected[$];
  int       send_idle_pct;
  int       recv_idle_pct;
  int       error_count = 0;
  int       quat_checked = 0;
  int       matrices_sent = 0;
  int       branch_seen[4] = '{0, 0, 0, 0};

  always #1 clk = ~clk;

  rotation_matrix_to_quaternion_unit u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  function automatic longint isqrt_floor(longint v);
    longint res = 0;
    longint bitv = 64'sd1 << 60;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp_out(longint v);
    if (v > OUT_HI) return OUT_HI;
    if (v < OUT_LO) return OUT_LO;
    return v;
  endfunction

  function automatic longint pair_quot(longint d, longint den);
    longint mag;
    mag = (d < 0) ? -d : d;
    mag = (mag << FRAC_BITS) / den;
    return clamp_out((d < 0) ? -mag : mag);
  endfunction

  function automatic rmq_out_t predict_quat(rmq_in_t m);
    longint a00 = m.m00, a01 = m.m01, a02 = m.m02;
    longint a10 = m.m10, a11 = m.m11, a12 = m.m12;
    longint a20 = m.m20, a21 = m.m21, a22 = m.m22;
    longint tr, rad, s, den;
    longint d[3];
    longint q[4];
    logic [1:0] br;
    rmq_out_t res;
    int k;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      br = BR_TRACE; rad = ONE_FX + tr;
      d[0] = a21 - a12; d[1] = a02 - a20; d[2] = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      br = BR_X; rad = ONE_FX + a00 - a11 - a22;
      d[0] = a21 - a12; d[1] = a10 + a01; d[2] = a02 + a20;
    end else if (a11 > a22) begin
      br = BR_Y; rad = ONE_FX + a11 - a00 - a22;
      d[0] = a02 - a20; d[1] = a10 + a01; d[2] = a21 + a12;
    end else begin
      br = BR_Z; rad = ONE_FX + a22 - a00 - a11;
      d[0] = a10 - a01; d[1] = a02 + a20; d[2] = a21 + a12;
    end
    q = '{0, 0, 0, 0};
    res.bad_input = (rad <= 0);
    if (rad > 0) begin
      s   = isqrt_floor(rad << FRAC_BITS);
      den = s << 1;
      k   = 0;
      for (int j = 0; j < 4; j++) begin
        if (j == br) begin
          q[j] = clamp_out(s >> 1);
        end else begin
          q[j] = pair_quot(d[k], den);
          k++;
        end
      end
    end
    res.qw = q[0];
    res.qx = q[1];
    res.qy = q[2];
    res.qz = q[3];
    res.branch_taken = br;
    return res;
  endfunction

  function automatic rmq_in_t make_matrix(longint a00, longint a01, longint a02,
                                          longint a10, longint a11, longint a12,
                                          longint a20, longint a21, longint a22);
    rmq_in_t m;
    m.m00 = a00; m.m01 = a01; m.m02 = a02;
    m.m10 = a10; m.m11 = a11; m.m12 = a12;
    m.m20 = a20; m.m21 = a21; m.m22 = a22;
    return m;
  endfunction

  function automatic rmq_in_t matrix_from_quat(longint w, longint x, longint y, longint z);
    longint n;
    n = w * w + x * x + y * y + z * z;
    if (n == 0) begin
      w = 1;
      n = 1;
    end
    return make_matrix(
      (w * w + x * x - y * y - z * z) * ONE_FX / n,
      2 * (x * y - w * z) * ONE_FX / n, 2 * (x * z + w * y) * ONE_FX / n,
      2 * (x * y + w * z) * ONE_FX / n,
      (w * w - x * x + y * y - z * z) * ONE_FX / n,
      2 * (y * z - w * x) * ONE_FX / n, 2 * (x * z - w * y) * ONE_FX / n,
      2 * (y * z + w * x) * ONE_FX / n,
      (w * w - x * x - y * y + z * z) * ONE_FX / n);
  endfunction

  task automatic send_matrix(rmq_in_t m);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= m;
    do @(posedge clk); while (!in_ready);
    quat_expected.push_back(predict_quat(m));
    matrices_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (quat_expected.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    rmq_out_t exp_q;
    if (rst_n && out_valid && out_ready) begin
      if (quat_expected.size() == 0) begin
        $error("unexpected quaternion result %h", out_data);
        error_count++;
      end else begin
        exp_q = quat_expected.pop_front();
        quat_checked++;
        branch_seen[out_data.branch_taken]++;
        if (out_data.qw !== exp_q.qw) begin
          $error("qw expected %0d actual %0d", exp_q.qw, out_data.qw);
          error_count++;
        end
        if (out_data.qx !== exp_q.qx) begin
          $error("qx expected %0d actual %0d", exp_q.qx, out_data.qx);
          error_count++;
        end
        if (out_data.qy !== exp_q.qy) begin
          $error("qy expected %0d actual %0d", exp_q.qy, out_data.qy);
          error_count++;
        end
        if (out_data.qz !== exp_q.qz) begin
          $error("qz expected %0d actual %0d", exp_q.qz, out_data.qz);
          error_count++;
        end
        if (out_data.branch_taken !== exp_q.branch_taken) begin
          $error("branch_taken expected %0d actual %0d", exp_q.branch_taken,
                 out_data.branch_taken);
          error_count++;
        end
        if (out_data.bad_input !== exp_q.bad_input) begin
          $error("bad_input expected %0d actual %0d", exp_q.bad_input,
                 out_data.bad_input);
          error_count++;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic test_directed();
    send_matrix(make_matrix(ONE_FX, 0, 0, 0, ONE_FX, 0, 0, 0, ONE_FX));
    send_matrix(make_matrix(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_matrix(make_matrix(ONE_FX, 0, 0, 0, -ONE_FX, 0, 0, 0, -ONE_FX));
    send_matrix(make_matrix(-ONE_FX, 0, 0, 0, ONE_FX, 0, 0, 0, -ONE_FX));
    send_matrix(make_matrix(-ONE_FX, 0, 0, 0, -ONE_FX, 0, 0, 0, ONE_FX));
    send_matrix(make_matrix(-ONE_FX, 0, 0, 0, -ONE_FX, 0, 0, 0, -ONE_FX));
    send_matrix(make_matrix(E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX, E_MAX));
    send_matrix(make_matrix(E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN, E_MIN));
    send_matrix(make_matrix(E_MIN, E_MAX, E_MIN, E_MAX, E_MIN, E_MAX, E_MIN, E_MAX, E_MIN));
    send_matrix(make_matrix(E_MAX, E_MIN, E_MAX, E_MIN, E_MIN, E_MIN, E_MAX, E_MIN, E_MIN));
    send_matrix(make_matrix(E_MIN, E_MAX, E_MIN, E_MIN, E_MAX, E_MAX, E_MAX, E_MIN, E_MIN));
    send_matrix(make_matrix(E_MIN, E_MIN, E_MAX, E_MAX, E_MIN, E_MIN, E_MIN, E_MAX, E_MAX));
    send_matrix(make_matrix(-5, E_MAX, 0, E_MIN, -5, 0, 0, 0, -5));
    send_matrix(make_matrix(0, 1, -1, 1, 0, -1, -1, 1, 0));
    send_matrix(make_matrix(E_MIN + 2, 0, 0, 0, E_MIN, 0, 0, 0, E_MIN));
    send_matrix(make_matrix(E_MAX, 0, 0, 0, E_MAX, 0, 0, 0, E_MIN));
    send_matrix(make_matrix(1, E_MAX, E_MAX, E_MIN, 0, E_MAX, E_MIN, E_MIN, -1));
    send_matrix(make_matrix(-ONE_FX, -1, 1, 1, ONE_FX / 2, 1, -1, 1, ONE_FX / 2));
    send_matrix(matrix_from_quat(1, 1, 0, 0));
    send_matrix(matrix_from_quat(0, 1, 1, 1));
  endtask

  task automatic test_rotations(int count);
    int lim;
    for (int i = 0; i < count; i++) begin
      lim = ($urandom_range(3) == 0) ? 3 : 1023;
      send_matrix(matrix_from_quat(
        longint'($urandom_range(2 * lim)) - lim, longint'($urandom_range(2 * lim)) - lim,
        longint'($urandom_range(2 * lim)) - lim, longint'($urandom_range(2 * lim)) - lim));
    end
  endtask

  task automatic test_raw(int count);
    rmq_in_t m;
    logic [DATA_WIDTH-1:0] e[9];
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(2);
      foreach (e[j]) begin
        e[j] = $urandom;
        if (mode == 1) e[j] = {{(DATA_WIDTH - 23){e[j][22]}}, e[j][22:0]};
        if (mode == 2) e[j] = {{(DATA_WIDTH - 4){e[j][3]}}, e[j][3:0]};
      end
      m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
      send_matrix(m);
    end
  endtask

  task automatic test_drain_pause();
    test_rotations(30);
    wait_drained();
    test_raw(10);
  endtask

  initial begin
    send_idle_pct = 29;
    recv_idle_pct = 60;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_rotations(400);
    test_raw(200);
    test_drain_pause();
    send_idle_pct = 60;
    recv_idle_pct = 29;
    test_rotations(400);
    test_raw(200);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_rotations(420);
    test_raw(220);
    wait_drained();
    repeat (60) @(posedge clk);
    $display("Sent %0d matrices, checked %0d quaternions, %0d errors.",
             matrices_sent, quat_checked, error_count);
    $display("Branches seen: trace %0d, x %0d, y %0d, z %0d.",
             branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3]);
    if (error_count == 0 && quat_expected.size() == 0) begin
      $display("rotation_matrix_to_quaternion_unit: match");
    end else begin
      $display("rotation_matrix_to_quaternion_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("rotation_matrix_to_quaternion_unit: mismatch");
    $finish;
  end

endmodule
